// ===== rtl/slc_pkg.sv =====
// Shared widths and the normalized word type for the slice index normalizer.
`timescale 1ns / 1ps
package slc_pkg;

  // Width of the signed index ports.
  localparam int PORT_W = 32;
  // Sequence length and slice count widths.
  localparam int LEN_W  = 31;
  localparam int CNT_W  = 31;
  // Normalized indices lie in [-1, length] and a step read from a 32-bit port
  // fits 33 signed bits, so every value after the front fits this width.
  localparam int VW     = 33;

  typedef struct packed {
    logic signed [VW-1:0] start;
    logic signed [VW-1:0] stop;
    logic signed [VW-1:0] step;
    logic                 neg;
    logic                 err;
  } slc_item_t;

endpackage

// ===== rtl/slc_front.sv =====
// Front part: applies defaults, wraps and clamps indices for one input word.
`timescale 1ns / 1ps
module slc_front #(
  parameter int INDEX_WIDTH = 32
) (
  input  logic [slc_pkg::LEN_W-1:0]         seq_length_i,
  input  logic signed [slc_pkg::PORT_W-1:0] start_value_i,
  input  logic                              start_absent_i,
  input  logic signed [slc_pkg::PORT_W-1:0] stop_value_i,
  input  logic                              stop_absent_i,
  input  logic signed [slc_pkg::PORT_W-1:0] step_value_i,
  input  logic                              step_absent_i,
  output slc_pkg::slc_item_t                item_o
);

  localparam int VW       = slc_pkg::VW;
  localparam int LEN_W    = slc_pkg::LEN_W;
  localparam int PORT_W   = slc_pkg::PORT_W;
  localparam bit SIGN_EN  = (INDEX_WIDTH <= PORT_W);
  localparam int SIGN_BIT = SIGN_EN ? INDEX_WIDTH - 1 : PORT_W - 1;

  // Low INDEX_WIDTH bits as two's complement; unsigned if INDEX_WIDTH > 32.
  function automatic logic signed [VW-1:0] ext_index(logic [PORT_W-1:0] p);
    logic [PORT_W-1:0] m;
    for (int i = 0; i < PORT_W; i++) begin
      if (i < INDEX_WIDTH) begin
        m[i] = p[i];
      end else begin
        m[i] = SIGN_EN ? p[SIGN_BIT] : 1'b0;
      end
    end
    return $signed({(SIGN_EN ? m[PORT_W-1] : 1'b0), m});
  endfunction

  // Wraps a negative index once by the length, then clamps to the range.
  function automatic logic signed [VW-1:0] fix_index(logic signed [VW-1:0] idx,
                                                     logic [LEN_W-1:0] len,
                                                     logic neg);
    logic signed [VW:0] w;
    logic signed [VW:0] l;
    l = $signed({{(VW+1-LEN_W){1'b0}}, len});
    w = {idx[VW-1], idx};
    if (w[VW]) begin
      w = w + l;
    end
    if (w[VW]) begin
      w = neg ? '1 : '0;
    end else if (w >= l) begin
      w = neg ? l - (VW+1)'(1) : l;
    end
    return w[VW-1:0];
  endfunction

  logic signed [VW-1:0] step;
  logic signed [VW-1:0] len_ext;
  logic                 neg;

  always_comb begin
    step    = step_absent_i ? VW'(1) : ext_index(step_value_i);
    neg     = step[VW-1];
    len_ext = $signed({{(VW-LEN_W){1'b0}}, seq_length_i});

    item_o.step = step;
    item_o.neg  = neg;
    item_o.err  = (step == '0);

    if (start_absent_i) begin
      item_o.start = neg ? len_ext - VW'(1) : '0;
    end else begin
      item_o.start = fix_index(ext_index(start_value_i), seq_length_i, neg);
    end

    if (stop_absent_i) begin
      item_o.stop = neg ? '1 : len_ext;
    end else begin
      item_o.stop = fix_index(ext_index(stop_value_i), seq_length_i, neg);
    end
  end

endmodule

// ===== rtl/slc_queue.sv =====
// Two-entry queue that decouples the front from the divider pipeline.
`timescale 1ns / 1ps
module slc_queue (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               push_i,
  input  slc_pkg::slc_item_t item_i,
  output logic               full_o,
  output logic               valid_o,
  input  logic               take_i,
  output slc_pkg::slc_item_t item_o
);

  slc_pkg::slc_item_t mem_q [2];
  logic       wr_ptr_q, wr_ptr_d;
  logic       rd_ptr_q, rd_ptr_d;
  logic [1:0] cnt_q, cnt_d;
  logic       do_push, do_pop;

  assign full_o  = (cnt_q == 2'd2);
  assign valid_o = (cnt_q != 2'd0);
  assign item_o  = mem_q[rd_ptr_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = take_i && valid_o;

  always_comb begin
    wr_ptr_d = do_push ? ~wr_ptr_q : wr_ptr_q;
    rd_ptr_d = do_pop ? ~rd_ptr_q : rd_ptr_q;
    cnt_d    = cnt_q + 2'(do_push) - 2'(do_pop);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= 2'd0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= item_i;
    end
  end

endmodule

// ===== rtl/slc_back.sv =====
// Back part: span and step magnitude, a one-bit-per-stage divider, output word.
`timescale 1ns / 1ps
module slc_back (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       q_valid_i,
  input  slc_pkg::slc_item_t         q_item_i,
  output logic                       q_take_o,
  output logic                       out_valid_o,
  input  logic                       out_stall_i,
  output logic signed [31:0]         norm_start_o,
  output logic signed [31:0]         norm_stop_o,
  output logic signed [31:0]         norm_step_o,
  output logic [slc_pkg::CNT_W-1:0]  slice_count_o,
  output logic                       zero_step_error_o
);

  localparam int VW    = slc_pkg::VW;
  localparam int LEN_W = slc_pkg::LEN_W;
  localparam int CNT_W = slc_pkg::CNT_W;
  // One divider stage for each bit of the span.
  localparam int NS    = LEN_W;

  typedef struct packed {
    slc_pkg::slc_item_t item;
    logic               act;
    logic [VW-1:0]      mag;
    logic [LEN_W-1:0]   diff;
    logic [LEN_W-1:0]   rem;
    logic [CNT_W-1:0]   quo;
  } div_stage_t;

  div_stage_t stg_q [NS+1];
  div_stage_t stg_d [NS+1];
  logic       vld_q [NS+1];
  logic       adv;
  logic       out_valid_q;

  // The whole pipeline moves unless a finished word is held at the output.
  assign adv      = !(out_valid_q && out_stall_i);
  assign q_take_o = adv;

  // Stage zero: the walk direction decides which way the span is measured.
  always_comb begin
    logic signed [VW:0] span;
    logic               walk;
    stg_d[0].item = q_item_i;
    if (q_item_i.neg) begin
      walk          = (q_item_i.stop < q_item_i.start);
      span          = {q_item_i.start[VW-1], q_item_i.start}
                      - {q_item_i.stop[VW-1], q_item_i.stop} - (VW+1)'(1);
      stg_d[0].mag  = VW'(0) - q_item_i.step;
    end else begin
      walk          = (q_item_i.start < q_item_i.stop);
      span          = {q_item_i.stop[VW-1], q_item_i.stop}
                      - {q_item_i.start[VW-1], q_item_i.start} - (VW+1)'(1);
      stg_d[0].mag  = q_item_i.step;
    end
    stg_d[0].act  = walk && !q_item_i.err;
    stg_d[0].diff = stg_d[0].act ? span[LEN_W-1:0] : '0;
    stg_d[0].rem  = '0;
    stg_d[0].quo  = '0;
  end

  for (genvar k = 1; k <= NS; k++) begin : g_div
    always_comb begin
      logic [LEN_W:0] trial;
      logic           ge;
      trial    = {stg_q[k-1].rem, stg_q[k-1].diff[LEN_W-k]};
      ge       = ({{(VW-LEN_W-1){1'b0}}, trial} >= stg_q[k-1].mag);
      stg_d[k] = stg_q[k-1];
      stg_d[k].rem = ge ? LEN_W'(trial - stg_q[k-1].mag[LEN_W:0])
                        : trial[LEN_W-1:0];
      stg_d[k].quo = {stg_q[k-1].quo[CNT_W-2:0], ge};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k <= NS; k++) begin
        vld_q[k] <= 1'b0;
      end
      out_valid_q <= 1'b0;
    end else if (adv) begin
      vld_q[0] <= q_valid_i;
      for (int k = 1; k <= NS; k++) begin
        vld_q[k] <= vld_q[k-1];
      end
      out_valid_q <= vld_q[NS];
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      for (int k = 0; k <= NS; k++) begin
        stg_q[k] <= stg_d[k];
      end
      norm_start_o      <= stg_q[NS].item.start[31:0];
      norm_stop_o       <= stg_q[NS].item.stop[31:0];
      norm_step_o       <= stg_q[NS].item.step[31:0];
      zero_step_error_o <= stg_q[NS].item.err;
      slice_count_o     <= stg_q[NS].act ? stg_q[NS].quo + CNT_W'(1) : '0;
    end
  end

  assign out_valid_o = out_valid_q;

  a_err_no_count : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && zero_step_error_o |-> slice_count_o == '0)
    else $error("zero step produced a nonzero count");

  a_err_step_zero : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && zero_step_error_o |-> norm_step_o == '0)
    else $error("error flag set with a nonzero step");

  a_count_direction : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && slice_count_o != '0 && !norm_step_o[31]
      |-> norm_start_o < norm_stop_o)
    else $error("forward count with start not below stop");

endmodule

// ===== rtl/slice_index_normalizer.sv =====
// Top level of the slice index normalizer.
//
//  channel | direction | handshake                | word
//  --------+-----------+--------------------------+---------------------------------
//  in      | input     | in_valid_i / in_stall_o  | length, start, stop, step + flags
//  out     | output    | out_valid_o / out_stall_i| start, stop, step, count, error
//
// One word is accepted per cycle while in_stall_o is low. An accepted word passes
// through the queue, the span stage and each of the 31 divider stages before
// the output register loads it; throughput is one word per cycle unless the
// output stalls.
// Reset clears the queue and all valid flags; nothing else is needed.
// A stalled output freezes the back pipeline, and the two-entry queue raises
// in_stall_o once it is full.
`timescale 1ns / 1ps
module slice_index_normalizer #(
  parameter int INDEX_WIDTH = 32
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       in_valid_i,
  output logic                       in_stall_o,
  input  logic [30:0]                seq_length_i,
  input  logic signed [31:0]         start_value_i,
  input  logic                       start_absent_i,
  input  logic signed [31:0]         stop_value_i,
  input  logic                       stop_absent_i,
  input  logic signed [31:0]         step_value_i,
  input  logic                       step_absent_i,
  output logic                       out_valid_o,
  input  logic                       out_stall_i,
  output logic signed [31:0]         norm_start_o,
  output logic signed [31:0]         norm_stop_o,
  output logic signed [31:0]         norm_step_o,
  output logic [30:0]                slice_count_o,
  output logic                       zero_step_error_o
);

  slc_pkg::slc_item_t front_item;
  slc_pkg::slc_item_t q_item;
  logic               q_full;
  logic               q_valid;
  logic               q_take;

  slc_front #(
    .INDEX_WIDTH(INDEX_WIDTH)
  ) u_front (
    .seq_length_i  (seq_length_i),
    .start_value_i (start_value_i),
    .start_absent_i(start_absent_i),
    .stop_value_i  (stop_value_i),
    .stop_absent_i (stop_absent_i),
    .step_value_i  (step_value_i),
    .step_absent_i (step_absent_i),
    .item_o        (front_item)
  );

  slc_queue u_queue (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (in_valid_i),
    .item_i (front_item),
    .full_o (q_full),
    .valid_o(q_valid),
    .take_i (q_take),
    .item_o (q_item)
  );

  assign in_stall_o = q_full;

  slc_back u_back (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .q_valid_i        (q_valid),
    .q_item_i         (q_item),
    .q_take_o         (q_take),
    .out_valid_o      (out_valid_o),
    .out_stall_i      (out_stall_i),
    .norm_start_o     (norm_start_o),
    .norm_stop_o      (norm_stop_o),
    .norm_step_o      (norm_step_o),
    .slice_count_o    (slice_count_o),
    .zero_step_error_o(zero_step_error_o)
  );

endmodule
